// ===== rtl/cgcu_pkg.sv =====
// ============================================================================
// cgcu_pkg: shared constants and elaboration-time table math
// Field layout of the stream channels, register indexes and reset values,
// and the fixed-point functions that build the steady-state gate table.
// ============================================================================
`default_nettype none

package cgcu_pkg;

    // Default sizes
    localparam int COMPARTMENTS_DEF  = 1024;
    localparam int TABLE_ENTRIES_DEF = 1024;

    // Stream field layout
    localparam int CMP_W    = 10;
    localparam int VAL_W    = 16;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 64;
    localparam int CUR_W    = 32;

    // Configuration registers
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSAL  = 1'd1;
    localparam logic [15:0] TIME_STEP_RST = 16'd1638;
    localparam logic [15:0] REVERSAL_RST  = 16'hA600;

    // Time constant: T = TAU_BASE - TAU_SLOPE * c below CA_SAT_CODE, else TAU_SAT
    localparam logic [15:0] CA_SAT_CODE = 16'd20480;
    localparam logic [20:0] TAU_BASE    = 21'd1556480;
    localparam logic [20:0] TAU_SLOPE   = 21'd72;
    localparam logic [20:0] TAU_SAT     = 21'd81920;

    // log2(0.35) in Q16.16
    localparam logic signed [63:0] KHALF_LOG2 = -64'sd99259;

    // Integer square root, one result bit per pass
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bm;
        x   = v;
        res = 64'd0;
        bm  = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (x >= res + bm) begin
                x   = x - (res + bm);
                res = (res >> 1) + bm;
            end else begin
                res = res >> 1;
            end
            bm = bm >> 2;
        end
        return res;
    endfunction

    // Repeated square roots of two, Q2.30
    function automatic logic [16:0][31:0] build_root2();
        logic [16:0][31:0] r;
        logic [63:0]       prev;
        prev = 64'd2 << 30;
        r[0] = prev[31:0];
        for (int k = 1; k <= 16; k++) begin
            prev = isqrt64(prev << 30);
            r[k] = prev[31:0];
        end
        return r;
    endfunction

    localparam logic [16:0][31:0] ROOT2 = build_root2();

    // Restoring long division
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [63:0] r;
        q = 64'd0;
        r = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], a[i]};
            if (r >= b) begin
                r    = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // log2 of c (c >= 1) in Q16.16 by repeated squaring
    function automatic logic [63:0] log2_q16(input logic [63:0] c);
        logic [63:0] y;
        logic [63:0] r;
        int          n;
        n = 0;
        for (int i = 1; i < 64; i++) begin
            if ((c >> i) != 64'd0) n = i;
        end
        y = (n <= 30) ? (c << (30 - n)) : (c >> (n - 30));
        r = 64'(n) << 16;
        for (int i = 0; i < 16; i++) begin
            y = (y * y) >> 30;
            if (y >= (64'd2 << 30)) begin
                y = y >> 1;
                r = r | (64'd1 << (15 - i));
            end
        end
        return r;
    endfunction

    // Steady-state open fraction for calcium code c, Q0.16
    function automatic logic [15:0] minf_of_code(input logic [63:0] c);
        logic signed [63:0] lca;
        logic signed [63:0] num;
        logic [63:0]        xpos;
        logic [63:0]        mant;
        logic [63:0]        p;
        logic [63:0]        m;
        int                 ip;
        int                 sh;
        if (c == 64'd0) return 16'd0;
        lca  = $signed(log2_q16(c)) - (64'sd12 <<< 16);
        num  = 64'sd46 * (KHALF_LOG2 - lca);
        xpos = 64'((num + 64'sd20971520) / 64'sd10);
        if (xpos >= (64'd48 << 16)) return 16'd0;
        if (xpos <= (64'd15 << 16)) return 16'hFFFF;
        ip   = int'(xpos >> 16) - 32;
        mant = 64'd1 << 30;
        for (int k = 1; k <= 16; k++) begin
            if (xpos[16-k]) mant = (mant * 64'(ROOT2[k])) >> 30;
        end
        sh = ip + 2;
        p  = (sh >= 0) ? (mant << sh) : (mant >> (-sh));
        m  = udiv64(64'd1 << 48, (64'd1 << 32) + p);
        return (m > 64'd65535) ? 16'hFFFF : m[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/calcium_gated_channel_update_core.sv =====
// ============================================================================
// calcium_gated_channel_update_core: calcium-gated K channel gate update
// Steady-state lookup, Crank-Nicolson gate step, conductance and current,
// one compartment per item in a 24-stage pipeline.
// ============================================================================
// Usage:
//   s_* channel: one compartment per item. s_tuser is the op (0 = set the
//   gate to steady state, 1 = integrate one step). m_* channel: one result
//   item per input item, in order.
//   cfg_* channel: writes time_step (index 0) and reversal_potential
//   (index 1); always ready, write only while no item is in flight.
//   Throughput: one item per cycle unless the output stalls or a hazard
//   holds the input. The gate of a compartment is read at entry and
//   written back at stage 22, so an update item whose compartment is
//   still in flight waits until that write-back.
//   The divide of the gate step is a 17-stage restoring divider, one
//   quotient bit per stage.
//   Reset (aresetn low, synchronous) empties the pipeline and restores the
//   register defaults; stored gates are undefined until first written.
//   When m_tready is low with a result waiting, the whole pipeline holds and
//   s_tready drops; nothing is lost or repeated.
`default_nettype none

module calcium_gated_channel_update_core #(
    parameter int COMPARTMENTS  = cgcu_pkg::COMPARTMENTS_DEF,
    parameter int TABLE_ENTRIES = cgcu_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // compartment[9:0], voltage[25:10], calcium[41:26], peak_conductance[57:42]
    input  wire logic [cgcu_pkg::S_DATA_W-1:0]      s_tdata,
    // op[0]
    input  wire logic                               s_tuser,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // gate[15:0], conductance[31:16], current[63:32]
    output logic [cgcu_pkg::M_DATA_W-1:0]           m_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [cgcu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [15:0]                        cfg_data
);

    import cgcu_pkg::*;

    localparam int IDX_W  = (COMPARTMENTS > 1) ? $clog2(COMPARTMENTS) : 1;
    localparam int ROM_W  = $clog2(TABLE_ENTRIES);
    localparam int DEN_W  = 26;
    localparam int NUM_W  = 43;
    localparam int DIV_N  = 17;

    typedef struct packed {
        logic               op;
        logic [IDX_W-1:0]   idx;
        logic [15:0]        minf;
        logic [15:0]        gbar;
        logic signed [16:0] drive;
    } side_t;

    localparam logic signed [33:0] CUR_MAX = 34'sd2147483647;
    localparam logic signed [33:0] CUR_MIN = -34'sd2147483648;

    // Wrap a compartment number into the store
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [CMP_W-1:0] v);
        logic [26:0] r;
        r = 27'(v);
        for (int k = CMP_W - 1; k >= 0; k--) begin
            if (r >= (27'(COMPARTMENTS) << k)) r = r - (27'(COMPARTMENTS) << k);
        end
        return r[IDX_W-1:0];
    endfunction

    // Steady-state table, built at elaboration
    logic [15:0] minf_rom [TABLE_ENTRIES];
    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_rom
        localparam logic [63:0] CK  = (64'(k) << 16) / TABLE_ENTRIES;
        localparam logic [15:0] VAL = minf_of_code(CK);
        assign minf_rom[k] = VAL;
    end

    // Input unpacking
    logic [CMP_W-1:0]  s_compartment;
    logic [15:0]       s_voltage;
    logic [15:0]       s_calcium;
    logic [15:0]       s_gbar;
    logic [IDX_W-1:0]  s_idx;
    logic [32:0]       rom_prod;
    logic [ROM_W-1:0]  rom_addr;

    assign s_compartment = s_tdata[9:0];
    assign s_voltage     = s_tdata[25:10];
    assign s_calcium     = s_tdata[41:26];
    assign s_gbar        = s_tdata[57:42];
    assign s_idx         = wrap_idx(s_compartment);
    assign rom_prod      = 33'(s_calcium) * 33'(TABLE_ENTRIES);
    assign rom_addr      = rom_prod[16 +: ROM_W];

    // Configuration registers
    logic [15:0]        time_step_reg;
    logic signed [15:0] reversal_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg <= TIME_STEP_RST;
            reversal_reg  <= REVERSAL_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TIME_STEP: time_step_reg <= cfg_data;
                CFG_REVERSAL:  reversal_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline registers
    logic               vld_s1_reg, vld_s2_reg, vld_s3_reg, vld_s4_reg;
    side_t              side_s1_reg, side_s2_reg, side_s3_reg, side_s4_reg;
    logic [15:0]        g0_s1_reg, g0_s2_reg;
    logic [20:0]        tau_s1_reg;
    logic [DEN_W-1:0]   den_s2_reg, den_s3_reg, den_s4_reg;
    logic [DEN_W-1:0]   dif_s2_reg;
    logic [19:0]        d10_s2_reg;
    logic [35:0]        p1_s3_reg;
    logic [41:0]        p2_s3_reg;
    logic [NUM_W-1:0]   num_s4_reg;

    logic               dv_vld_reg  [DIV_N];
    side_t              dv_side_reg [DIV_N];
    logic [DEN_W-1:0]   dv_den_reg  [DIV_N];
    logic [NUM_W-1:0]   dv_rem_reg  [DIV_N];
    logic [DIV_N-1:0]   dv_q_reg    [DIV_N];
    logic [NUM_W-1:0]   dv_rem_next [DIV_N];
    logic [DIV_N-1:0]   dv_q_next   [DIV_N];

    logic               vld_g_reg;
    side_t              side_g_reg;
    logic [15:0]        gate_g_reg;
    logic [15:0]        gate_next;

    logic               vld_c_reg;
    logic [15:0]        gate_c_reg;
    logic [15:0]        cond_c_reg;
    logic signed [16:0] drive_c_reg;
    logic [31:0]        cond_prod;

    logic               out_vld_reg;
    logic [15:0]        out_gate_reg;
    logic [15:0]        out_cond_reg;
    logic [CUR_W-1:0]   out_cur_reg;
    logic signed [33:0] cur_full;
    logic [CUR_W-1:0]   cur_sat;

    logic               en;
    logic               hazard;
    logic               accept;

    // Global advance: hold everything while a result waits
    assign en       = !out_vld_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign s_tready = en && !hazard;

    // Hold an update whose compartment is still in flight before write-back
    always_comb begin
        hazard = (vld_s1_reg && side_s1_reg.idx == s_idx) ||
                 (vld_s2_reg && side_s2_reg.idx == s_idx) ||
                 (vld_s3_reg && side_s3_reg.idx == s_idx) ||
                 (vld_s4_reg && side_s4_reg.idx == s_idx) ||
                 (vld_g_reg  && side_g_reg.idx  == s_idx);
        for (int j = 0; j < DIV_N; j++) begin
            if (dv_vld_reg[j] && dv_side_reg[j].idx == s_idx) hazard = 1'b1;
        end
        hazard = hazard && s_tuser;
    end

    // Gate store: read at entry, write back from the gate stage
    logic [15:0] gate_mem [COMPARTMENTS];

    always_ff @(posedge aclk) begin
        if (en) begin
            g0_s1_reg <= gate_mem[s_idx];
            if (vld_g_reg) gate_mem[side_g_reg.idx] <= gate_g_reg;
        end
    end

    // Divider: one quotient bit per stage
    always_comb begin
        for (int j = 0; j < DIV_N; j++) begin
            logic [NUM_W-1:0] rem_in;
            logic [DEN_W-1:0] den_in;
            logic [DIV_N-1:0] q_in;
            logic [NUM_W-1:0] dsh;
            rem_in = (j == 0) ? num_s4_reg : dv_rem_reg[(j == 0) ? 0 : j - 1];
            den_in = (j == 0) ? den_s4_reg : dv_den_reg[(j == 0) ? 0 : j - 1];
            q_in   = (j == 0) ? '0 : dv_q_reg[(j == 0) ? 0 : j - 1];
            dsh    = NUM_W'(den_in) << (DIV_N - 1 - j);
            if (rem_in >= dsh) begin
                dv_rem_next[j] = rem_in - dsh;
                dv_q_next[j]   = {q_in[DIV_N-2:0], 1'b1};
            end else begin
                dv_rem_next[j] = rem_in;
                dv_q_next[j]   = {q_in[DIV_N-2:0], 1'b0};
            end
        end
    end

    // Gate select and saturation
    always_comb begin
        logic [DIV_N-1:0] q;
        q = dv_q_reg[DIV_N-1];
        if (!dv_side_reg[DIV_N-1].op) begin
            gate_next = dv_side_reg[DIV_N-1].minf;
        end else if (q[DIV_N-1]) begin
            gate_next = 16'hFFFF;
        end else begin
            gate_next = q[15:0];
        end
    end

    // Conductance and current
    assign cond_prod = 32'(side_g_reg.gbar) * 32'(gate_g_reg);
    assign cur_full  = $signed({18'd0, cond_c_reg}) *
                       $signed({{17{drive_c_reg[16]}}, drive_c_reg});

    always_comb begin
        if (cur_full > CUR_MAX) begin
            cur_sat = CUR_MAX[CUR_W-1:0];
        end else if (cur_full < CUR_MIN) begin
            cur_sat = CUR_MIN[CUR_W-1:0];
        end else begin
            cur_sat = cur_full[CUR_W-1:0];
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_s1_reg  <= 1'b0;
            vld_s2_reg  <= 1'b0;
            vld_s3_reg  <= 1'b0;
            vld_s4_reg  <= 1'b0;
            vld_g_reg   <= 1'b0;
            vld_c_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int j = 0; j < DIV_N; j++) dv_vld_reg[j] <= 1'b0;
        end else if (en) begin
            vld_s1_reg  <= accept;
            vld_s2_reg  <= vld_s1_reg;
            vld_s3_reg  <= vld_s2_reg;
            vld_s4_reg  <= vld_s3_reg;
            dv_vld_reg[0] <= vld_s4_reg;
            for (int j = 1; j < DIV_N; j++) dv_vld_reg[j] <= dv_vld_reg[j-1];
            vld_g_reg   <= dv_vld_reg[DIV_N-1];
            vld_c_reg   <= vld_g_reg;
            out_vld_reg <= vld_c_reg;
        end
    end

    // Payload: advance all stages together
    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1: table read, time constant, driving force
            side_s1_reg.op    <= s_tuser;
            side_s1_reg.idx   <= s_idx;
            side_s1_reg.minf  <= minf_rom[rom_addr];
            side_s1_reg.gbar  <= s_gbar;
            side_s1_reg.drive <= $signed({s_voltage[15], s_voltage}) -
                                 $signed({reversal_reg[15], reversal_reg});
            tau_s1_reg <= (s_calcium < CA_SAT_CODE) ?
                          TAU_BASE - 21'(s_calcium) * TAU_SLOPE : TAU_SAT;

            // stage 2: step weights
            side_s2_reg <= side_s1_reg;
            g0_s2_reg   <= g0_s1_reg;
            den_s2_reg  <= (DEN_W'(tau_s1_reg) << 5) + DEN_W'(time_step_reg) * DEN_W'(5);
            dif_s2_reg  <= (DEN_W'(tau_s1_reg) << 5) - DEN_W'(time_step_reg) * DEN_W'(5);
            d10_s2_reg  <= 20'(time_step_reg) * 20'd10;

            // stage 3: products
            side_s3_reg <= side_s2_reg;
            den_s3_reg  <= den_s2_reg;
            p1_s3_reg   <= 36'(d10_s2_reg) * 36'(side_s2_reg.minf);
            p2_s3_reg   <= 42'(g0_s2_reg) * 42'(dif_s2_reg);

            // stage 4: numerator with rounding half
            side_s4_reg <= side_s3_reg;
            den_s4_reg  <= den_s3_reg;
            num_s4_reg  <= NUM_W'(p1_s3_reg) + NUM_W'(p2_s3_reg) +
                           NUM_W'(den_s3_reg >> 1);

            // divider stages
            dv_side_reg[0] <= side_s4_reg;
            dv_den_reg[0]  <= den_s4_reg;
            for (int j = 1; j < DIV_N; j++) begin
                dv_side_reg[j] <= dv_side_reg[j-1];
                dv_den_reg[j]  <= dv_den_reg[j-1];
            end
            for (int j = 0; j < DIV_N; j++) begin
                dv_rem_reg[j] <= dv_rem_next[j];
                dv_q_reg[j]   <= dv_q_next[j];
            end

            // gate stage
            side_g_reg <= dv_side_reg[DIV_N-1];
            gate_g_reg <= gate_next;

            // conductance stage
            gate_c_reg  <= gate_g_reg;
            cond_c_reg  <= cond_prod[31:16];
            drive_c_reg <= side_g_reg.drive;

            // output stage
            out_gate_reg <= gate_c_reg;
            out_cond_reg <= cond_c_reg;
            out_cur_reg  <= cur_sat;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_cur_reg, out_cond_reg, out_gate_reg};

endmodule

`default_nettype wire

// ===== rtl/cgcu_checker.sv =====
// ============================================================================
// cgcu_checker: port-level checks for the gate update core
// Watches the stream and configuration ports of the top level over time.
// ============================================================================
`default_nettype none

module cgcu_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_tready,
    input wire logic [cgcu_pkg::M_DATA_W-1:0]      m_tdata,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic                               cfg_valid,
    input wire logic                               cfg_ready
);

    import cgcu_pkg::*;

    // Stalled result holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Reset empties the output
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Input is held off while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken during output stall");

    // A closed gate carries no conductance and no current
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[15:0] == 16'd0 |->
            m_tdata[31:16] == 16'd0 && m_tdata[63:32] == 32'd0)
        else $error("current through a closed gate");

    // Configuration writes are never refused
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind calcium_gated_channel_update_core cgcu_checker u_cgcu_checker (.*);

`default_nettype wire

// ===== bench/calcium_gated_channel_update_core_tb.sv =====
// ============================================================================
// calcium_gated_channel_update_core_tb: self-checking bench for the gate core
// Streams compartment items with directed corners and random content through
// several register settings and idling mixes. Each result item is checked
// against an in-bench predictor that keeps its own gate store and table.
// ============================================================================
`default_nettype none

module calcium_gated_channel_update_core_tb;

    import cgcu_pkg::*;

    localparam int     NCOMP      = 1024;
    localparam int     NTAB       = 1024;
    localparam int     DRAIN_WAIT = 40;
    localparam longint CYCLE_CAP  = 600000;

    // Packed from the top bit down, so the gate sits in the low bits
    typedef struct packed {
        logic [31:0] current;
        logic [15:0] conductance;
        logic [15:0] gate;
    } sk_result_t;

    // ------------------------------------------------------------------------
    // Gate predictor and result store
    // ------------------------------------------------------------------------
    class sk_gate_tracker;
        logic [15:0]  minf_tab [NTAB];
        longint unsigned root2 [17];
        logic [15:0]  gate_mem [NCOMP];
        bit           written  [NCOMP];
        logic [15:0]  step_q16;
        logic [15:0]  e_rev;
        sk_result_t   pending_q [$];
        int           mismatches;

        function new();
            root2[0] = 64'd2 << 30;
            for (int k = 1; k <= 16; k++) root2[k] = int_sqrt(root2[k-1] << 30);
            for (int k = 0; k < NTAB; k++) minf_tab[k] = steady_gate((k * 65536) / NTAB);
            for (int k = 0; k < NCOMP; k++) written[k] = 0;
            step_q16   = TIME_STEP_RST;
            e_rev      = REVERSAL_RST;
            mismatches = 0;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned acc;
            longint unsigned bm;
            acc = 0;
            bm  = 64'd1 << 62;
            while (bm > v) bm = bm >> 2;
            while (bm != 0) begin
                if (v >= acc + bm) begin
                    v   = v - (acc + bm);
                    acc = (acc >> 1) + bm;
                end else begin
                    acc = acc >> 1;
                end
                bm = bm >> 2;
            end
            return acc;
        endfunction

        // log2 in Q16.16 by squaring a Q2.30 mantissa
        function longint unsigned log2_fix(longint unsigned c);
            int              msb;
            longint unsigned y;
            longint unsigned r;
            msb = 0;
            while (msb < 63 && (c >> (msb + 1)) != 0) msb++;
            y = (msb <= 30) ? (c << (30 - msb)) : (c >> (msb - 30));
            r = longint'(msb) << 16;
            for (int i = 0; i < 16; i++) begin
                y = (y * y) >> 30;
                if (y >= (64'd2 << 30)) begin
                    y = y >> 1;
                    r = r | (64'd1 << (15 - i));
                end
            end
            return r;
        endfunction

        // 1/(1+(0.35/ca)^4.6) for one calcium code, Q0.16
        function logic [15:0] steady_gate(longint unsigned c);
            longint          lca;
            longint          num;
            longint unsigned xq;
            longint unsigned mant;
            longint unsigned pw;
            longint unsigned q;
            int              sh;
            if (c == 0) return 16'd0;
            lca = longint'(log2_fix(c)) - (longint'(12) << 16);
            num = 46 * (-99259 - lca);
            xq  = longint'(num + 20971520) / 10;
            if (xq >= (64'd48 << 16)) return 16'd0;
            if (xq <= (64'd15 << 16)) return 16'hFFFF;
            mant = 64'd1 << 30;
            for (int k = 1; k <= 16; k++)
                if ((xq >> (16 - k)) & 1) mant = (mant * root2[k]) >> 30;
            sh = int'(xq >> 16) - 30;
            pw = (sh >= 0) ? (mant << sh) : (mant >> (-sh));
            q  = (64'd1 << 48) / ((64'd1 << 32) + pw);
            return (q > 65535) ? 16'hFFFF : q[15:0];
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            if (idx == CFG_TIME_STEP) step_q16 = val;
            else if (idx == CFG_REVERSAL) e_rev = val;
        endfunction

        // Work out the result of one accepted item and queue it
        function void note_item(bit op, logic [9:0] cmp, logic signed [15:0] volt,
                                logic [15:0] ca, logic [15:0] gbar);
            longint unsigned m;
            longint unsigned t;
            longint unsigned den;
            longint unsigned nm;
            longint unsigned g;
            longint unsigned cond;
            longint          cur;
            sk_result_t      r;
            m = minf_tab[(longint'(ca) * NTAB) >> 16];
            if (op == 1'b0) begin
                g = m;
            end else begin
                t   = (ca < CA_SAT_CODE) ? (1556480 - 72 * longint'(ca)) : 81920;
                den = 32 * t + 5 * longint'(step_q16);
                nm  = 10 * longint'(step_q16) * m
                      + longint'(gate_mem[cmp]) * (32 * t - 5 * longint'(step_q16));
                g   = (nm + den / 2) / den;
                if (g > 65535) g = 65535;
            end
            gate_mem[cmp] = g[15:0];
            written[cmp]  = 1;
            cond = (longint'(gbar) * g) >> 16;
            cur  = longint'(cond) * (longint'(volt) - longint'($signed(e_rev)));
            if (cur > 64'sd2147483647) cur = 64'sd2147483647;
            if (cur < -64'sd2147483648) cur = -64'sd2147483648;
            r.gate        = g[15:0];
            r.conductance = cond[15:0];
            r.current     = cur[31:0];
            pending_q.push_back(r);
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data);
            sk_result_t want;
            sk_result_t got;
            got = data;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result item %h", $time, data);
                mismatches++;
                return;
            end
            want = pending_q.pop_front();
            if (got.gate !== want.gate) begin
                $display("%0t: gate exp %h got %h", $time, want.gate, got.gate);
                mismatches++;
            end
            if (got.conductance !== want.conductance) begin
                $display("%0t: conductance exp %h got %h", $time,
                         want.conductance, got.conductance);
                mismatches++;
            end
            if (got.current !== want.current) begin
                $display("%0t: current exp %h got %h", $time, want.current, got.current);
                mismatches++;
            end
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic [S_DATA_W-1:0]      s_tdata;
    logic                     s_tuser;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [M_DATA_W-1:0]      m_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [15:0]              cfg_data;

    sk_gate_tracker tracker;
    int             send_idle_pct;
    int             recv_stall_pct;
    longint         cycle_count;

    calcium_gated_channel_update_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Stall the receiver at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check every accepted result item
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_result(m_tdata);
    end

    // Hard stop on a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("calcium_gated_channel_update_core_tb: done, errors");
            $finish;
        end
    end

    task automatic send_item(bit op, logic [9:0] cmp, logic [15:0] volt,
                             logic [15:0] ca, logic [15:0] gbar);
        // never integrate a gate that was never set
        if (op && !tracker.written[cmp]) op = 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, gbar, ca, volt, cmp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_item(op, cmp, volt, ca, gbar);
    endtask

    // Drain the pipeline, then let it settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tracker.pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        tracker.set_register(idx, val);
    endtask

    task automatic set_registers(logic [15:0] dt, logic [15:0] ek);
        wait_drained();
        write_reg(CFG_TIME_STEP, dt);
        write_reg(CFG_REVERSAL, ek);
        @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_field();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_calcium();
        case ($urandom_range(7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return CA_SAT_CODE - 16'd1;
            3: return CA_SAT_CODE;
            4, 5: return 16'($urandom_range(int'(CA_SAT_CODE) - 1));
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly integration steps on a small hot set to exercise gate hazards
    task automatic run_random(int n);
        logic [9:0] cmp;
        bit         op;
        for (int i = 0; i < n; i++) begin
            cmp = ($urandom_range(3) != 0) ? 10'($urandom_range(15)) : 10'($urandom);
            op  = ($urandom_range(99) < 75);
            send_item(op, cmp, pick_field(), pick_calcium(), pick_field());
        end
    endtask

    initial begin
        tracker        = new();
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tuser        = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_TIME_STEP;
        cfg_data       = 16'd0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corners with reset register values
        send_item(1'b0, 10'd0,    16'h0000, 16'd0,      16'hFFFF);
        send_item(1'b0, 10'd1,    16'h7FFF, 16'hFFFF,   16'hFFFF);
        send_item(1'b0, 10'd2,    16'h8000, 16'hFFFF,   16'hFFFF);
        send_item(1'b0, 10'd3,    16'h1234, 16'd20479,  16'h0100);
        send_item(1'b0, 10'd4,    16'hF000, 16'd20480,  16'h0000);
        send_item(1'b0, 10'd1023, 16'h0100, 16'd63,     16'h8000);
        send_item(1'b0, 10'd5,    16'h0100, 16'd64,     16'h4000);
        send_item(1'b0, 10'd6,    16'h0100, 16'd5734,   16'hFFFF);
        send_item(1'b1, 10'd0,    16'h0000, 16'hFFFF,   16'hFFFF);
        send_item(1'b1, 10'd0,    16'h7FFF, 16'hFFFF,   16'hFFFF);
        send_item(1'b1, 10'd1,    16'h8000, 16'd0,      16'hFFFF);
        send_item(1'b1, 10'd3,    16'h0000, 16'd20479,  16'h00FF);
        send_item(1'b1, 10'd4,    16'h7FFF, 16'd20480,  16'hFFFF);
        send_item(1'b1, 10'd1023, 16'h8000, 16'd1,      16'h0001);
        send_item(1'b1, 10'd1023, 16'h8000, 16'hFFFF,   16'hFFFF);
        send_item(1'b1, 10'd6,    16'h5A5A, 16'hA5A5,   16'h5A5A);

        // Zero step holds the gate; extreme reversal on the low side
        set_registers(16'd0, 16'h8000);
        send_item(1'b1, 10'd1, 16'h7FFF, 16'h8000, 16'hFFFF);
        send_item(1'b1, 10'd1, 16'h7FFF, 16'd0,    16'hFFFF);
        run_random(140);

        // Largest step, reversal high, starved sender
        set_registers(16'hFFFF, 16'h7FFF);
        send_idle_pct = 87;
        send_item(1'b1, 10'd2, 16'h8000, 16'd0,    16'hFFFF);
        send_item(1'b1, 10'd2, 16'h8000, 16'hFFFF, 16'hFFFF);
        run_random(130);

        // Defaults again, stalled receiver
        set_registers(TIME_STEP_RST, REVERSAL_RST);
        send_idle_pct  = 0;
        recv_stall_pct = 87;
        run_random(130);

        // Random registers, both sides idling
        set_registers(16'($urandom), 16'($urandom));
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        run_random(130);

        wait_drained();
        if (tracker.mismatches == 0) begin
            $display("calcium_gated_channel_update_core_tb: done, clean");
        end else begin
            $display("calcium_gated_channel_update_core_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
